[sv/kfp_pkg.sv]
// shared types and constants for the keyframe timeline player
package kfp_pkg;

	localparam int MODE_W      = 2;
	localparam int SLOT_IDX_W  = 7;
	localparam int FRAME_W     = 16;
	localparam int DUR_W       = 16;
	localparam int TICK_W      = 32;
	localparam int LEN_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int ENTRY_W     = FRAME_W + DUR_W;
	localparam int S_TDATA_W   = 40;
	localparam int S_TUSER_W   = MODE_W;
	localparam int M_TDATA_W   = 48;
	localparam int M_TUSER_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 2'd2;

	localparam logic [LEN_W-1:0]   LENGTH_RST = 8'd1;
	localparam logic [FRAME_W-1:0] LIMIT_RST  = 16'd1;
	localparam logic [TICK_W-1:0]  LOOP_RST   = 32'd0;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD    = 2'd0,
		MODE_TICK    = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic wr;
		logic restart;
		logic start;
		logic step;
		logic latch;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic at_last;
	} status_t;

	typedef struct packed {
		logic [SLOT_IDX_W-1:0] entry_index;
		logic [FRAME_W-1:0]    entry_frame;
		logic [DUR_W-1:0]      entry_duration;
	} load_t;

endpackage

[sv/kfp_ram.sv]
// generic single-port-write, registered-read ram
module kfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/kfp_ctrl.sv]
// controller state machine for the timeline player
module kfp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [kfp_pkg::MODE_W-1:0] mode,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	input  kfp_pkg::status_t           sts,
	output kfp_pkg::cmd_t              cmd
);

	kfp_pkg::state_t state_q;
	kfp_pkg::state_t state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kfp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			kfp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (kfp_pkg::mode_t'(mode))
						kfp_pkg::MODE_LOAD: begin
							cmd.wr = 1'b1;
						end
						kfp_pkg::MODE_RESTART: begin
							cmd.restart = 1'b1;
						end
						kfp_pkg::MODE_TICK: begin
							cmd.start = 1'b1;
							state_d   = kfp_pkg::ST_WALK;
						end
						default: begin
						end
					endcase
				end
			end
			kfp_pkg::ST_WALK: begin
				if (sts.hit || sts.at_last) begin
					cmd.latch = 1'b1;
					state_d   = kfp_pkg::ST_EMIT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			kfp_pkg::ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = kfp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kfp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/kfp_dp.sv]
// datapath: config registers, timeline ram, duration walk, tick counter, result register
module kfp_dp #(
	parameter int MAX_SLOTS = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kfp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kfp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  kfp_pkg::load_t                      load,
	input  kfp_pkg::cmd_t                       cmd,
	output kfp_pkg::status_t                    sts,
	output logic [kfp_pkg::FRAME_W-1:0]         frame_index,
	output logic [kfp_pkg::TICK_W-1:0]          tick_used,
	output logic                                past_end,
	output logic                                frame_clamped
);

	localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SW  = kfp_pkg::DUR_W + $clog2(MAX_SLOTS + 1);
	localparam int IXW = AW + kfp_pkg::SLOT_IDX_W + 1;

	logic [kfp_pkg::LEN_W-1:0]   len_q;
	logic [kfp_pkg::FRAME_W-1:0] limit_q;
	logic [kfp_pkg::TICK_W-1:0]  loop_q;
	logic [kfp_pkg::TICK_W-1:0]  tick_q;
	logic [AW-1:0]               idx_q;
	logic [AW-1:0]               last_q;
	logic [SW-1:0]               sum_q;
	logic [kfp_pkg::FRAME_W-1:0] pick_frame_q;
	logic                        pick_past_q;
	logic                        pick_clamp_q;
	logic [kfp_pkg::FRAME_W-1:0] out_frame_q;
	logic [kfp_pkg::TICK_W-1:0]  out_tick_q;
	logic                        out_past_q;
	logic                        out_clamp_q;

	logic [IXW-1:0]                wide_idx;
	logic                          wr_en;
	logic [AW-1:0]                 raddr;
	logic [kfp_pkg::ENTRY_W-1:0]   rdata;
	logic [kfp_pkg::FRAME_W-1:0]   rd_frame;
	logic [kfp_pkg::DUR_W-1:0]     rd_dur;
	logic [SW-1:0]                 sum_nxt;
	logic [31:0]                   used_n;
	logic [31:0]                   used_last;
	logic [kfp_pkg::TICK_W-1:0]    total;
	logic [kfp_pkg::TICK_W-1:0]    tick_inc;
	logic [kfp_pkg::TICK_W-1:0]    tick_nxt;

	// slot address, widened so the range check works at any depth
	assign wide_idx = {{(AW + 1){1'b0}}, load.entry_index};
	assign wr_en    = cmd.wr && (wide_idx < IXW'(MAX_SLOTS));

	always_comb begin
		if (cmd.start) begin
			raddr = '0;
		end else if (cmd.step) begin
			raddr = AW'(idx_q + 1'b1);
		end else begin
			raddr = idx_q;
		end
	end

	kfp_ram #(
		.WIDTH(kfp_pkg::ENTRY_W),
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wide_idx[AW-1:0]),
		.wdata({load.entry_duration, load.entry_frame}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_frame = rdata[kfp_pkg::FRAME_W-1:0];
	assign rd_dur   = rdata[kfp_pkg::ENTRY_W-1:kfp_pkg::FRAME_W];
	assign sum_nxt  = sum_q + SW'(rd_dur);

	assign sts.hit     = tick_q < kfp_pkg::TICK_W'(sum_nxt);
	assign sts.at_last = idx_q == last_q;

	// entry count clipped to one..depth
	always_comb begin
		used_n = {24'd0, len_q};
		if (used_n == 32'd0) begin
			used_n = 32'd1;
		end
		if (used_n > 32'(MAX_SLOTS)) begin
			used_n = 32'(MAX_SLOTS);
		end
		used_last = used_n - 32'd1;
	end

	assign total    = (loop_q == '0) ? kfp_pkg::TICK_W'(1) : loop_q;
	assign tick_inc = tick_q + 1'b1;
	assign tick_nxt = (tick_inc >= total) ? '0 : tick_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= kfp_pkg::LENGTH_RST;
			limit_q <= kfp_pkg::LIMIT_RST;
			loop_q  <= kfp_pkg::LOOP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kfp_pkg::REG_LENGTH: len_q   <= cfg_data[kfp_pkg::LEN_W-1:0];
				kfp_pkg::REG_LIMIT:  limit_q <= cfg_data[kfp_pkg::FRAME_W-1:0];
				kfp_pkg::REG_LOOP:   loop_q  <= cfg_data[kfp_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (cmd.restart) begin
			tick_q <= '0;
		end else if (cmd.emit) begin
			tick_q <= tick_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q  <= '0;
			sum_q  <= '0;
			last_q <= used_last[AW-1:0];
		end else if (cmd.step) begin
			idx_q <= AW'(idx_q + 1'b1);
			sum_q <= sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			pick_past_q <= !sts.hit;
			if (rd_frame >= limit_q) begin
				pick_frame_q <= '0;
				pick_clamp_q <= 1'b1;
			end else begin
				pick_frame_q <= rd_frame;
				pick_clamp_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_frame_q <= pick_frame_q;
			out_tick_q  <= tick_q;
			out_past_q  <= pick_past_q;
			out_clamp_q <= pick_clamp_q;
		end
	end

	assign frame_index   = out_frame_q;
	assign tick_used     = out_tick_q;
	assign past_end      = out_past_q;
	assign frame_clamped = out_clamp_q;

endmodule

[sv/keyframe_timeline_player_top.sv]
// top level of the keyframe timeline player
// load and restart items leave the block idle; a tick item holds the block through the walk and emit states
// and its result is registered on leaving the emit state, which waits while an earlier result is stalled
// the walk reads one timeline entry per cycle from the single read port of the ram
// a result waits in the output register while the next item is taken
// asynchronous reset sets tick to 0 and the config registers to their defaults; ram contents undefined
module keyframe_timeline_player_top #(
	parameter int MAX_SLOTS = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [kfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kfp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// entry_index, entry_frame, entry_duration
	input  logic [kfp_pkg::S_TDATA_W-1:0]     s_tdata,
	// mode
	input  logic [kfp_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// frame_index, tick_used
	output logic [kfp_pkg::M_TDATA_W-1:0]     m_tdata,
	// past_end, frame_clamped
	output logic [kfp_pkg::M_TUSER_W-1:0]     m_tuser
);

	kfp_pkg::cmd_t               cmd;
	kfp_pkg::status_t            sts;
	kfp_pkg::load_t              load;
	logic [kfp_pkg::FRAME_W-1:0] frame_index;
	logic [kfp_pkg::TICK_W-1:0]  tick_used;
	logic                        past_end;
	logic                        frame_clamped;

	assign load.entry_index    = s_tdata[6:0];
	assign load.entry_frame    = s_tdata[22:7];
	assign load.entry_duration = s_tdata[38:23];

	kfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.mode    (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	kfp_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.load         (load),
		.cmd          (cmd),
		.sts          (sts),
		.frame_index  (frame_index),
		.tick_used    (tick_used),
		.past_end     (past_end),
		.frame_clamped(frame_clamped)
	);

	assign m_tdata = {tick_used, frame_index};
	assign m_tuser = {frame_clamped, past_end};

endmodule

[sv/kfp_chk.sv]
// port checker for the timeline player and its bind
module kfp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [kfp_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [kfp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [kfp_pkg::M_TUSER_W-1:0] m_tuser
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// busy while walking after a tick request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == kfp_pkg::MODE_TICK) |=> !s_tready)
		else $error("request taken during walk");

	// a clamped frame reads as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[15:0] == 16'd0)
		else $error("clamped frame not zero");

	// no result straight after any request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

bind keyframe_timeline_player_top kfp_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
